[hw/rtl/tdbe_pkg.sv]
// Shared widths, reset values, register indexes and types for the tone detector.
`default_nettype none

package tdbe_pkg;

  localparam int SAMPLE_W = 8;
  localparam int FILT_W   = 16;
  localparam int LEVEL_W  = 7;
  localparam int COUNT_W  = 8;
  localparam int HOLD_W   = 7;
  localparam int DIV_W    = 8;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDER = 1'b1;

  localparam logic [HOLD_W-1:0]  HOLD_RESET  = 7'd8;
  localparam logic [DIV_W-1:0]   DIV_RESET   = 8'd8;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd8;

  // Offset-binary to two's complement
  localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 8'h80;

  typedef struct packed {
    logic [HOLD_W-1:0] hold_samples;
    logic [DIV_W-1:0]  tick_divider;
  } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/tdbe_resonator.sv]
// Two-pole shift-and-add resonator with its two delay registers.
`default_nettype none

module tdbe_resonator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic [tdbe_pkg::SAMPLE_W-1:0]    sample,
  output logic signed [tdbe_pkg::FILT_W-1:0] filtered
);
  import tdbe_pkg::*;

  logic signed [FILT_W-1:0] delay_c, delay_e;
  logic signed [FILT_W-1:0] delay_c_next, delay_e_next;
  logic [SAMPLE_W-1:0]      s;
  logic signed [FILT_W-1:0] x, b, y, t1, t2, t3;

  always_comb begin
    s  = sample ^ SIGN_FLIP;
    // signed, halved, placed in the high byte
    x  = {s[SAMPLE_W-1], s[SAMPLE_W-1:1], {(FILT_W-SAMPLE_W){1'b0}}};
    b  = (x - delay_e) >>> 4;
    y  = b + delay_e;
    // y * 45/32 as a shift-add chain, truncating at each shift
    t1 = (y >>> 2) + y;
    t2 = (t1 >>> 1) + y;
    t3 = t2 >>> 2;
    delay_e_next = (y + t3) - delay_c;
    delay_c_next = y + b;
  end

  assign filtered = y;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_c <= '0;
      delay_e <= '0;
    end else if (advance) begin
      delay_c <= delay_c_next;
      delay_e <= delay_e_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tdbe_decide.sv]
// Peak-hold envelope, decision tick counter and hysteresis tone flag.
`default_nettype none

module tdbe_decide (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  tdbe_pkg::cfg_t                     cfg,
  input  logic signed [tdbe_pkg::FILT_W-1:0] filtered,
  output logic [tdbe_pkg::LEVEL_W-1:0]       envelope,
  output logic                               tick,
  output logic                               tone_present
);
  import tdbe_pkg::*;

  logic [LEVEL_W-1:0] peak_level, peak_level_next;
  logic [COUNT_W-1:0] hold_count, hold_count_next;
  logic [COUNT_W-1:0] tick_count, tick_count_next;
  logic [LEVEL_W-1:0] threshold, threshold_next;
  logic               tone_flag, tone_flag_next;
  logic [LEVEL_W-1:0] top;
  logic [LEVEL_W-1:0] half;

  always_comb begin
    top  = filtered[FILT_W-2:FILT_W-1-LEVEL_W];
    half = threshold >> 1;

    hold_count_next = hold_count - 1'b1;
    peak_level_next = (hold_count_next == '0) ? '0 : peak_level;
    if (!filtered[FILT_W-1] && (peak_level_next <= top)) begin
      peak_level_next = top;
      hold_count_next = {1'b0, cfg.hold_samples};
    end

    tick_count_next = tick_count - 1'b1;
    tick            = 1'b0;
    threshold_next  = threshold;
    tone_flag_next  = tone_flag;
    if (tick_count_next == '0) begin
      tick_count_next = cfg.tick_divider;
      tick            = 1'b1;
      if (threshold < (peak_level_next >> 1)) begin
        tone_flag_next = 1'b1;
        threshold_next = peak_level_next;
      end else if (half >= peak_level_next) begin
        tone_flag_next = 1'b0;
        threshold_next = half + 1'b1;
      end
    end

    envelope     = peak_level_next;
    tone_present = tone_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_level <= '0;
      hold_count <= COUNT_RESET;
      tick_count <= COUNT_RESET;
      threshold  <= '0;
      tone_flag  <= 1'b0;
    end else if (advance) begin
      peak_level <= peak_level_next;
      hold_count <= hold_count_next;
      tick_count <= tick_count_next;
      threshold  <= threshold_next;
      tone_flag  <= tone_flag_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tone_detector_bandpass_envelope_unit.sv]
// Top level: input register, resonator, envelope/decision and result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------
//   in      | to block  | in_valid / in_stall | sample
//   out     | from block| out_valid/out_stall | filtered, envelope, tick, tone_present
//   cfg     | to block  | cfg_we              | cfg_index, cfg_data
//
// One sample per clock sustained while out_stall is low. Filter and decision state
// advance in the cycle a beat moves from the input register to the result register.
// Synchronous reset clears both registers' valid flags and the filter/decision
// state, reloading the hold and tick counters with COUNT_RESET. A stalled result
// keeps its beat; the input register holds one more beat before in_stall rises.
`default_nettype none

module tone_detector_bandpass_envelope_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tdbe_pkg::SAMPLE_W-1:0]      sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tdbe_pkg::FILT_W-1:0] filtered,
  output logic [tdbe_pkg::LEVEL_W-1:0]       envelope,
  output logic                               tick,
  output logic                               tone_present,
  input  logic                               cfg_we,
  input  logic [tdbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdbe_pkg::CFG_W-1:0]         cfg_data
);
  import tdbe_pkg::*;

  cfg_t                     cfg;
  logic                     in_full;
  logic [SAMPLE_W-1:0]      in_sample;
  logic                     advance;
  logic signed [FILT_W-1:0] filt_c;
  logic [LEVEL_W-1:0]       env_c;
  logic                     tick_c;
  logic                     tone_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_samples <= HOLD_RESET;
      cfg.tick_divider <= DIV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD_SAMPLES: cfg.hold_samples <= cfg_data[HOLD_W-1:0];
        REG_TICK_DIVIDER: cfg.tick_divider <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_sample <= sample;
    end
  end

  tdbe_resonator u_resonator (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .sample   (in_sample),
    .filtered (filt_c)
  );

  tdbe_decide u_decide (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .cfg          (cfg),
    .filtered     (filt_c),
    .envelope     (env_c),
    .tick         (tick_c),
    .tone_present (tone_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered     <= filt_c;
      envelope     <= env_c;
      tick         <= tick_c;
      tone_present <= tone_c;
    end
  end

endmodule

`default_nettype wire
